### rtl/frc_pkg.sv
package frc_pkg;

  // Field widths
  localparam int IdW  = 30;
  localparam int CntW = 6;

  // Default number of cells in the chain
  localparam int CapacityDefault = 32;

  // Configuration port
  localparam int       CfgDataW   = 32;
  localparam int       CfgAddrW   = 3;
  localparam logic     RegCapIdx  = 1'b0;
  localparam logic [CntW-1:0] CapResetVal = 6'd32;

  // Per-cell control, driven by the top level
  typedef struct packed {
    logic insert;   // shift toward older cells, newest takes the request
    logic drain;    // shift toward newer cells during the dump
    logic keep;     // cell lies below the effective capacity
  } cell_ctrl_t;

endpackage

### rtl/frc_cell.sv
module frc_cell
  import frc_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cell_ctrl_t     ctrl_i,
  input  logic [IdW-1:0] lookup_id_i,
  input  logic [IdW-1:0] newer_id_i,
  input  logic           newer_valid_i,
  input  logic [IdW-1:0] older_id_i,
  input  logic           older_valid_i,
  output logic [IdW-1:0] id_o,
  output logic           valid_o,
  output logic           hit_o
);

  logic [IdW-1:0] id_d, id_q;
  logic           valid_d, valid_q;

  always_comb begin
    id_d    = id_q;
    valid_d = valid_q;
    if (ctrl_i.insert) begin
      id_d    = newer_id_i;
      valid_d = newer_valid_i & ctrl_i.keep;
    end else if (ctrl_i.drain) begin
      id_d    = older_id_i;
      valid_d = older_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign id_o    = id_q;
  assign valid_o = valid_q;
  assign hit_o   = valid_q & (id_q == lookup_id_i);

endmodule

### rtl/fifo_replacement_recent_set_core.sv
// FIFO replacement set: holds up to capacity_in_use distinct identifiers.
//
// Input: a request is taken at a rising edge with start high and busy low.
// item_id_i is compared against every held entry in the same cycle; a hit
// changes nothing, a miss inserts the id as the newest entry and evicts the
// oldest ones beyond the effective capacity. Ordinary requests go at one per
// cycle with busy low throughout.
// A request with end_of_sequence_i set is handled the same way, then the
// block raises busy and dumps the set: one entry per cycle on entry_id_o,
// marked by result_valid_o, newest first, starting the cycle after the
// request. last_entry_o flags the oldest and busy drops with it. The set is
// empty afterwards.
// Storage is a chain of cells, cell 0 newest; entries move one cell per
// insert, and shift back toward cell 0 during the dump.
// Results are held for exactly one cycle; the receiver cannot stall them.
// Configuration: APB register capacity_in_use at byte address 0 (0 acts as
// 1, values above CAPACITY clamp). Write it only while the block is idle.
// Reset empties the set, clears busy and sets capacity_in_use to 32.
module fifo_replacement_recent_set_core
  import frc_pkg::*;
#(
  parameter int CAPACITY = CapacityDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                start,
  output logic                busy,
  input  logic [IdW-1:0]      item_id_i,
  input  logic                end_of_sequence_i,
  // result channel
  output logic                result_valid_o,
  output logic [IdW-1:0]      entry_id_o,
  output logic [CntW-1:0]     entry_count_o,
  output logic                last_entry_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  localparam int CapW = $clog2(CAPACITY + 1);
  localparam int ExtW = (CapW > CntW) ? CapW : CntW;

  localparam logic StIdle = 1'b0;
  localparam logic StDump = 1'b1;

  // ---------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------
  logic [CntW-1:0] cap_cfg_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[CfgAddrW-1] == RegCapIdx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_cfg_q <= CapResetVal;
    end else if (cfg_wr) begin
      cap_cfg_q <= pwdata[CntW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[CfgAddrW-1] == RegCapIdx) begin
      prdata = CfgDataW'(cap_cfg_q);
    end
  end

  // Effective capacity: zero acts as one, clamp to the chain length
  logic [ExtW-1:0] cap_ext;
  logic [CapW-1:0] cap_eff;

  always_comb begin
    cap_ext = ExtW'(cap_cfg_q);
    if (cap_ext == '0) begin
      cap_ext = ExtW'(1);
    end else if (cap_ext > ExtW'(CAPACITY)) begin
      cap_ext = ExtW'(CAPACITY);
    end
    cap_eff = cap_ext[CapW-1:0];
  end

  // ---------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------
  logic            state_d, state_q;
  logic [CapW-1:0] held_d, held_q;
  logic            accept, miss, insert, dump_last;

  logic [IdW-1:0]      cell_id    [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] cell_hit;

  assign busy   = (state_q == StDump);
  assign accept = start & ~busy;
  assign miss   = ~|cell_hit;
  assign insert = accept & miss;

  // Oldest entry reached when the next cell is empty
  generate
    if (CAPACITY > 1) begin : g_last
      assign dump_last = ~cell_valid[1];
    end else begin : g_last_one
      assign dump_last = 1'b1;
    end
  endgenerate

  always_comb begin
    state_d = state_q;
    held_d  = held_q;
    case (state_q)
      StIdle: begin
        if (insert) begin
          // full set: oldest entries drop so the count settles at capacity
          held_d = (held_q >= cap_eff) ? cap_eff : held_q + CapW'(1);
        end
        if (accept && end_of_sequence_i) begin
          state_d = StDump;
        end
      end
      StDump: begin
        if (dump_last) begin
          state_d = StIdle;
          held_d  = '0;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      held_q  <= '0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
    end
  end

  // ---------------------------------------------------------------
  // Cell chain, cell 0 newest
  // ---------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctrl_t     ctrl;
    logic [IdW-1:0] newer_id, older_id;
    logic           newer_valid, older_valid;

    assign ctrl = '{insert: insert, drain: busy, keep: (CapW'(i) < cap_eff)};

    if (i == 0) begin : g_head
      assign newer_id    = item_id_i;
      assign newer_valid = 1'b1;
    end else begin : g_body
      assign newer_id    = cell_id[i-1];
      assign newer_valid = cell_valid[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign older_id    = '0;
      assign older_valid = 1'b0;
    end else begin : g_inner
      assign older_id    = cell_id[i+1];
      assign older_valid = cell_valid[i+1];
    end

    frc_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .lookup_id_i   (item_id_i),
      .newer_id_i    (newer_id),
      .newer_valid_i (newer_valid),
      .older_id_i    (older_id),
      .older_valid_i (older_valid),
      .id_o          (cell_id[i]),
      .valid_o       (cell_valid[i]),
      .hit_o         (cell_hit[i])
    );
  end

  // ---------------------------------------------------------------
  // Results: cell 0 is shown each dump cycle, then the chain shifts
  // ---------------------------------------------------------------
  logic [ExtW-1:0] held_ext;

  assign held_ext       = ExtW'(held_q);
  assign result_valid_o = busy;
  assign entry_id_o     = cell_id[0];
  assign entry_count_o  = held_ext[CntW-1:0];
  assign last_entry_o   = busy & dump_last;

endmodule
